// ===== design/mm_pkg.sv =====
// ----------------------------------------------------------------------------
// mm_pkg
// Shared widths, register indexes and control bundles for the matrix multiplier.
// ----------------------------------------------------------------------------
package mm_pkg;

  // field widths
  localparam int ELEM_W = 16;
  localparam int PROD_W = 35;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 4;
  localparam int REG_W  = 2;
  localparam int ACC_W  = 40;

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [REG_W-1:0] REG_INNER_LEN = 2'd1;
  localparam logic [REG_W-1:0] REG_COLS_B    = 2'd2;

  // element tags
  localparam logic MODE_A = 1'b0;
  localparam logic MODE_B = 1'b1;

  // sequencer to datapath
  typedef struct packed {
    logic             issue;
    logic             first;
    logic             lastk;
    logic             load;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } mac_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic done;
    logic free;
  } mac_stat_t;

endpackage

// ===== design/mm_store.sv =====
// ----------------------------------------------------------------------------
// mm_store
// Element memories for A and B, one write and one registered read port each.
// ----------------------------------------------------------------------------
module mm_store
  import mm_pkg::*;
#(
  parameter int MAX_DIM = 8,
  localparam int DEPTH  = MAX_DIM * MAX_DIM,
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we_a,
  input  logic                     we_b,
  input  logic [AW-1:0]            waddr,
  input  logic signed [ELEM_W-1:0] wdata,
  input  logic [AW-1:0]            raddr_a,
  input  logic [AW-1:0]            raddr_b,
  output logic signed [ELEM_W-1:0] rdata_a,
  output logic signed [ELEM_W-1:0] rdata_b
);

  logic signed [ELEM_W-1:0] mem_a [DEPTH];
  logic signed [ELEM_W-1:0] mem_b [DEPTH];

  // matrix a port
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[waddr] <= wdata;
    end
    rdata_a <= mem_a[raddr_a];
  end

  // matrix b port
  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[waddr] <= wdata;
    end
    rdata_b <= mem_b[raddr_b];
  end

endmodule

// ===== design/mm_mac.sv =====
// ----------------------------------------------------------------------------
// mm_mac
// Multiply-accumulate pipeline with saturation and the result register.
// ----------------------------------------------------------------------------
module mm_mac
  import mm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctrl_t                ctrl,
  input  logic signed [ELEM_W-1:0] rdata_a,
  input  logic signed [ELEM_W-1:0] rdata_b,
  output mac_stat_t                stat,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [PROD_W-1:0] product_value,
  output logic [IDX_W-1:0]         result_row,
  output logic [IDX_W-1:0]         result_col,
  output logic                     last
);

  localparam logic signed [ACC_W-1:0] PV_MAX = ACC_W'((64'sd1 <<< (PROD_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] PV_MIN = ACC_W'(-(64'sd1 <<< (PROD_W - 1)));

  logic                         s1_v;
  logic                         s1_first;
  logic                         s1_lastk;
  logic                         s2_v;
  logic                         s2_first;
  logic                         s2_lastk;
  logic signed [2*ELEM_W-1:0]   prod;
  logic signed [ACC_W-1:0]      acc;
  logic                         done;
  logic signed [PROD_W-1:0]     sat_val;

  // flags follow the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      done <= 1'b0;
    end else begin
      s1_v <= ctrl.issue;
      s2_v <= s1_v;
      done <= s2_v && s2_lastk;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    s1_first <= ctrl.first;
    s1_lastk <= ctrl.lastk;
    s2_first <= s1_first;
    s2_lastk <= s1_lastk;
    prod     <= rdata_a * rdata_b;
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (s2_v) begin
      acc <= (s2_first ? '0 : acc) + ACC_W'(prod);
    end
  end

  // clamp to result width
  always_comb begin
    if (acc > PV_MAX) begin
      sat_val = PROD_W'(PV_MAX);
    end else if (acc < PV_MIN) begin
      sat_val = PROD_W'(PV_MIN);
    end else begin
      sat_val = PROD_W'(acc);
    end
  end

  assign stat.done = done;
  assign stat.free = !out_valid || !out_stall;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      product_value <= sat_val;
      result_row    <= ctrl.row;
      result_col    <= ctrl.col;
      last          <= ctrl.last;
    end
  end

endmodule

// ===== design/mm_seq.sv =====
// ----------------------------------------------------------------------------
// mm_seq
// Load counters and the sequencer that walks rows, columns and inner terms.
// ----------------------------------------------------------------------------
module mm_seq
  import mm_pkg::*;
#(
  parameter int MAX_DIM = 8,
  localparam int DEPTH  = MAX_DIM * MAX_DIM,
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int DW     = $clog2(MAX_DIM + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [DW-1:0]            dim_m,
  input  logic [DW-1:0]            dim_n,
  input  logic [DW-1:0]            dim_p,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     mode,
  output logic                     we_a,
  output logic                     we_b,
  output logic [AW-1:0]            waddr,
  output logic [AW-1:0]            raddr_a,
  output logic [AW-1:0]            raddr_b,
  output mac_ctrl_t                ctrl,
  input  mac_stat_t                stat
);

  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] cnt_a;
  logic [CW-1:0] cnt_b;
  logic [CW-1:0] cnt_a_next;
  logic [CW-1:0] cnt_b_next;
  logic [CW-1:0] need_a;
  logic [CW-1:0] need_b;
  logic [IW-1:0] i;
  logic [IW-1:0] j;
  logic [IW-1:0] k;
  logic [AW-1:0] a_base;
  logic [AW-1:0] a_addr;
  logic [AW-1:0] b_addr;
  logic          accept;
  logic          k_last;
  logic          j_last;
  logic          i_last;

  assign need_a = CW'(dim_m) * CW'(dim_n);
  assign need_b = CW'(dim_n) * CW'(dim_p);

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // store write for an accepted element, dropped once full
  assign we_a  = accept && (mode == MODE_A) && (cnt_a < need_a);
  assign we_b  = accept && (mode == MODE_B) && (cnt_b < need_b);
  assign waddr = we_b ? cnt_b[AW-1:0] : cnt_a[AW-1:0];

  assign cnt_a_next = we_a ? cnt_a + CW'(1) : cnt_a;
  assign cnt_b_next = we_b ? cnt_b + CW'(1) : cnt_b;

  assign k_last = (DW'(k) == dim_n - DW'(1));
  assign j_last = (DW'(j) == dim_p - DW'(1));
  assign i_last = (DW'(i) == dim_m - DW'(1));

  assign raddr_a = a_addr;
  assign raddr_b = b_addr;

  // datapath control
  always_comb begin
    ctrl       = '0;
    ctrl.issue = (state == ST_RUN);
    ctrl.first = (k == '0);
    ctrl.lastk = k_last;
    ctrl.load  = (state == ST_OUT) && stat.free;
    ctrl.row   = IDX_W'(i);
    ctrl.col   = IDX_W'(j);
    ctrl.last  = i_last && j_last;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt_a <= '0;
      cnt_b <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          cnt_a <= cnt_a_next;
          cnt_b <= cnt_b_next;
          if (accept && (cnt_a_next >= need_a) && (cnt_b_next >= need_b)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (k_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (stat.done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (stat.free) begin
            if (i_last && j_last) begin
              state <= ST_IDLE;
              cnt_a <= '0;
              cnt_b <= '0;
            end else begin
              state <= ST_RUN;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // row, column and address walk
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        i      <= '0;
        j      <= '0;
        k      <= '0;
        a_base <= '0;
        a_addr <= '0;
        b_addr <= '0;
      end
      ST_RUN: begin
        if (!k_last) begin
          k      <= k + IW'(1);
          a_addr <= a_addr + AW'(1);
          b_addr <= b_addr + AW'(dim_p);
        end
      end
      ST_OUT: begin
        if (stat.free) begin
          k <= '0;
          if (j_last) begin
            i      <= i + IW'(1);
            j      <= '0;
            a_base <= a_base + AW'(dim_n);
            a_addr <= a_base + AW'(dim_n);
            b_addr <= '0;
          end else begin
            j      <= j + IW'(1);
            a_addr <= a_base;
            b_addr <= AW'(j) + AW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply
// Integer matrix multiply D = A x B over element memories and one shared MAC.
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   -------   ------------------   ---------------------------------------------
//   input     in_valid / in_stall  mode, element_value
//   output    out_valid/out_stall  product_value, result_row, result_col, last
//   config    cfg_we               cfg_index, cfg_data
//
// Loading accepts one element per cycle while in_stall is low. The completing element
// starts the product; each result then passes through the single multiply-accumulate
// pipeline (memory read, multiply, accumulate, result register). in_stall stays high
// until the last result is loaded into the result register. A stalled result register
// holds the sequencer.
// Reset is synchronous and clears counters and control; the memories are not cleared.
//
module matrix_multiply
  import mm_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [REG_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     mode,
  input  logic signed [ELEM_W-1:0] element_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [PROD_W-1:0] product_value,
  output logic [IDX_W-1:0]         result_row,
  output logic [IDX_W-1:0]         result_col,
  output logic                     last
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = $clog2(MAX_DIM + 1);

  logic [CFG_W-1:0]         rows_a;
  logic [CFG_W-1:0]         inner_len;
  logic [CFG_W-1:0]         cols_b;
  logic [DW-1:0]            dim_m;
  logic [DW-1:0]            dim_n;
  logic [DW-1:0]            dim_p;
  logic                     we_a;
  logic                     we_b;
  logic [AW-1:0]            waddr;
  logic [AW-1:0]            raddr_a;
  logic [AW-1:0]            raddr_b;
  logic signed [ELEM_W-1:0] rdata_a;
  logic signed [ELEM_W-1:0] rdata_b;
  mac_ctrl_t                ctrl;
  mac_stat_t                stat;

  // clamp a dimension register into 1..MAX_DIM
  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= CFG_W'(8);
      inner_len <= CFG_W'(8);
      cols_b    <= CFG_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_A:    rows_a    <= cfg_data;
        REG_INNER_LEN: inner_len <= cfg_data;
        REG_COLS_B:    cols_b    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign dim_m = clamp_dim(rows_a);
  assign dim_n = clamp_dim(inner_len);
  assign dim_p = clamp_dim(cols_b);

  // sequencer and load counters
  mm_seq #(
    .MAX_DIM (MAX_DIM)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .dim_m    (dim_m),
    .dim_n    (dim_n),
    .dim_p    (dim_p),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .we_a     (we_a),
    .we_b     (we_b),
    .waddr    (waddr),
    .raddr_a  (raddr_a),
    .raddr_b  (raddr_b),
    .ctrl     (ctrl),
    .stat     (stat)
  );

  // element memories
  mm_store #(
    .MAX_DIM (MAX_DIM)
  ) u_store (
    .clk     (clk),
    .we_a    (we_a),
    .we_b    (we_b),
    .waddr   (waddr),
    .wdata   (element_value),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // multiply-accumulate and result register
  mm_mac u_mac (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .rdata_a       (rdata_a),
    .rdata_b       (rdata_b),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .product_value (product_value),
    .result_row    (result_row),
    .result_col    (result_col),
    .last          (last)
  );

endmodule

// ===== sim/matrix_multiply_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_multiply_test
// Self-checking bench for the matrix multiplier: loads A and B element streams
// under changing dimensions and idle patterns, predicts every D element and
// compares each output transfer in order against the prediction.
// ----------------------------------------------------------------------------
module matrix_multiply_test;
  import mm_pkg::*;

  localparam int MAX_DIM       = 8;
  localparam int RANDOM_ITEMS  = 220;
  localparam int PHASE_ITEMS   = 28;
  localparam int SETTLE_CYCLES = 30;
  localparam longint LIMIT_NS  = 64'd20_000_000;

  // index with no register behind it, writes there are ignored
  localparam logic [REG_W-1:0] REG_SPARE = 2'd3;

  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7fff;

  typedef struct packed {
    logic                    mode;
    logic signed [ELEM_W-1:0] value;
  } elem_item_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] value;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic                     last;
  } d_elem_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [REG_W-1:0]         cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     mode = MODE_A;
  logic signed [ELEM_W-1:0] element_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [PROD_W-1:0] product_value;
  logic [IDX_W-1:0]         result_row;
  logic [IDX_W-1:0]         result_col;
  logic                     last;

  matrix_multiply #(.MAX_DIM(MAX_DIM)) uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .element_value(element_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .product_value(product_value), .result_row(result_row),
    .result_col(result_col), .last(last)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // pending element transfers and predicted D elements
  elem_item_t elem_q[$];
  d_elem_t    due_results[$];

  // bench copy of registers and load state
  logic [CFG_W-1:0]         rows_code  = 4'd8;
  logic [CFG_W-1:0]         inner_code = 4'd8;
  logic [CFG_W-1:0]         cols_code  = 4'd8;
  logic signed [ELEM_W-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic signed [ELEM_W-1:0] b_mem [MAX_DIM*MAX_DIM];
  int                       a_loaded = 0;
  int                       b_loaded = 0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  logic in_taken    = 1'b0;

  int err_count     = 0;
  int results_seen  = 0;
  int products_done = 0;
  int elems_sent    = 0;
  int elems_dropped = 0;
  int random_items  = 0;
  int phase_count   = 0;

  // out-of-range codes clamp to 1 .. MAX_DIM
  function automatic int dim_of(input logic [CFG_W-1:0] code);
    if (code == 0) return 1;
    if (code > MAX_DIM) return MAX_DIM;
    return int'(code);
  endfunction

  // store one element, and once both matrices are full, compute all of D
  task automatic absorb_element(input logic m, input logic signed [ELEM_W-1:0] v);
    int      nr, nk, nc, i, j, k;
    longint  acc;
    d_elem_t d;
    nr = dim_of(rows_code);
    nk = dim_of(inner_code);
    nc = dim_of(cols_code);
    if (m == MODE_A) begin
      if (a_loaded < nr * nk) begin
        a_mem[a_loaded] = v;
        a_loaded++;
      end else begin
        elems_dropped++;
      end
    end else begin
      if (b_loaded < nk * nc) begin
        b_mem[b_loaded] = v;
        b_loaded++;
      end else begin
        elems_dropped++;
      end
    end
    if (a_loaded >= nr * nk && b_loaded >= nk * nc) begin
      for (i = 0; i < nr; i++) begin
        for (j = 0; j < nc; j++) begin
          acc = 0;
          for (k = 0; k < nk; k++)
            acc += longint'(a_mem[i*nk + k]) * longint'(b_mem[k*nc + j]);
          // at most 8 * 2^30 in magnitude, so never beyond 35 bits
          d.value = acc[PROD_W-1:0];
          d.row   = i[IDX_W-1:0];
          d.col   = j[IDX_W-1:0];
          d.last  = (i == nr - 1) && (j == nc - 1);
          due_results.push_back(d);
        end
      end
      a_loaded = 0;
      b_loaded = 0;
      products_done++;
    end
  endtask

  // input driver, a new transfer only once the previous one was taken
  always @(negedge clk) begin : drive_elements
    elem_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (elem_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = elem_q.pop_front();
        in_valid      <= 1'b1;
        mode          <= nxt.mode;
        element_value <= nxt.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: predict on input transfers, check output transfers
  always @(posedge clk) begin : track_results
    d_elem_t got, want;
    if (rst) begin
      in_taken   <= 1'b0;
      a_loaded   = 0;
      b_loaded   = 0;
      rows_code  = 4'd8;
      inner_code = 4'd8;
      cols_code  = 4'd8;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        elems_sent++;
        absorb_element(mode, element_value);
      end
      if (out_valid && !out_stall) begin
        got.value = product_value;
        got.row   = result_row;
        got.col   = result_col;
        got.last  = last;
        results_seen++;
        if (due_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result: value %0d row %0d col %0d last %0b",
                   $time, got.value, got.row, got.col, got.last);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            err_count++;
            $display({"%0t: mismatch: expected value %0d row %0d col %0d last %0b, ",
                      "actual value %0d row %0d col %0d last %0b"},
                     $time, want.value, want.row, want.col, want.last,
                     got.value, got.row, got.col, got.last);
          end
        end
      end
    end
  end

  // register write while the block is idle
  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ROWS_A:    rows_code  = val;
      REG_INNER_LEN: inner_code = val;
      REG_COLS_B:    cols_code  = val;
      default: ;
    endcase
  endtask

  task automatic push_element(input logic m, input logic signed [ELEM_W-1:0] v);
    elem_item_t it;
    it.mode  = m;
    it.value = v;
    elem_q.push_back(it);
  endtask

  // all transfers done, nothing predicted outstanding, then a short pause
  task automatic wait_idle();
    while (elem_q.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // extremes and sign boundaries weighted up
  function automatic logic signed [ELEM_W-1:0] rand_element();
    logic signed [ELEM_W-1:0] v;
    case ($urandom_range(9))
      0: v = ELEM_MIN;
      1: v = ELEM_MAX;
      2: v = '0;
      3: v = '1;
      default: v = ELEM_W'($urandom);
    endcase
    return v;
  endfunction

  // mostly small dimensions, sometimes zero or clamped-large codes
  function automatic logic [CFG_W-1:0] rand_dim_code();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 4'd0;
    if (r < 20) return 4'($urandom_range(8, 15));
    return 4'($urandom_range(1, 4));
  endfunction

  // one complete load of A and B, randomly interleaved, with surplus noise
  task automatic load_product(inout int counted);
    int  na, nb, ca, cb;
    logic m;
    na = dim_of(rows_code) * dim_of(inner_code);
    nb = dim_of(inner_code) * dim_of(cols_code);
    ca = 0;
    cb = 0;
    while (ca < na || cb < nb) begin
      m = 1'($urandom_range(1));
      if ((m == MODE_A && ca >= na) || (m == MODE_B && cb >= nb)) begin
        if ($urandom_range(9) == 0) begin
          push_element(m, rand_element());
          continue;
        end
        m = !m;
      end
      push_element(m, rand_element());
      if (m == MODE_A) ca++;
      else cb++;
      counted++;
    end
  endtask

  initial begin : stimulus
    int i, phase_items;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // 1x1x1 from zero codes, surplus A dropped, most negative squared
    write_reg(REG_ROWS_A, 4'd0);
    write_reg(REG_INNER_LEN, 4'd1);
    write_reg(REG_COLS_B, 4'd0);
    write_reg(REG_SPARE, 4'd5);
    push_element(MODE_A, ELEM_MIN);
    push_element(MODE_A, 16'sd5);
    push_element(MODE_B, ELEM_MIN);
    wait_idle();

    // full inner length from a clamped code, largest possible sum
    write_reg(REG_ROWS_A, 4'd1);
    write_reg(REG_INNER_LEN, 4'd15);
    write_reg(REG_COLS_B, 4'd1);
    for (i = 0; i < MAX_DIM; i++) begin
      push_element(MODE_A, ELEM_MIN);
      push_element(MODE_B, ELEM_MIN);
    end
    wait_idle();

    // partial load, then shrink inner length so the counts already suffice
    write_reg(REG_ROWS_A, 4'd2);
    write_reg(REG_INNER_LEN, 4'd2);
    write_reg(REG_COLS_B, 4'd2);
    push_element(MODE_A, ELEM_MAX);
    push_element(MODE_A, ELEM_MIN);
    push_element(MODE_A, 16'sd0);
    push_element(MODE_A, -16'sd1);
    push_element(MODE_B, ELEM_MAX);
    push_element(MODE_B, -16'sd1);
    wait_idle();
    write_reg(REG_INNER_LEN, 4'd1);
    push_element(MODE_B, 16'sd1234);
    wait_idle();

    // random phases, rotating through the idle patterns
    while (random_items < RANDOM_ITEMS) begin
      case (phase_count % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 55; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 55; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      write_reg(REG_ROWS_A, rand_dim_code());
      write_reg(REG_INNER_LEN, rand_dim_code());
      write_reg(REG_COLS_B, rand_dim_code());
      phase_items = 0;
      while (phase_items < PHASE_ITEMS)
        load_product(phase_items);
      wait_idle();
      random_items += phase_items;
      phase_count++;
    end

    $display("run covered %0d element transfers (%0d surplus dropped), %0d products",
             elems_sent, elems_dropped, products_done);
    $display("%0d result elements compared over %0d random dimension settings",
             results_seen, phase_count);
    if (err_count == 0) begin
      $display("** matrix_multiply: PASSED **");
    end else begin
      $display("** matrix_multiply: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("** matrix_multiply: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mm_pkg.sv
design/mm_store.sv
design/mm_mac.sv
design/mm_seq.sv
design/matrix_multiply.sv
sim/matrix_multiply_test.sv
